// ===== rtl/dfs_topo_pkg.sv =====
// Shared constants and controller/datapath handshake types for the DFS topological sort unit.
package dfs_topo_pkg;

  localparam int OPCODE_W = 2;
  localparam int VERTEX_W = 4;
  localparam int COUNT_W  = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  localparam logic [OPCODE_W-1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RUN      = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic run_start;
    logic add_edge;
    logic clear_graph;
    logic scan_next;
    logic push_scan;
    logic push_open;
    logic row_rd;
    logic pop;
    logic stack_rd;
    logic top_load;
    logic emit_rd;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic scan_unvisited;
    logic open_any;
    logic depth_one;
    logic fcount_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/dfs_topo_cmd_if.sv =====
// Command channel interface: opcode and edge endpoints with valid/ready.
interface dfs_topo_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [dfs_topo_pkg::OPCODE_W-1:0]  opcode;
  logic [dfs_topo_pkg::VERTEX_W-1:0]  from_vertex;
  logic [dfs_topo_pkg::VERTEX_W-1:0]  to_vertex;

  modport source (output valid, output opcode, output from_vertex, output to_vertex,
                  input ready);
  modport sink (input valid, input opcode, input from_vertex, input to_vertex,
                output ready);
endinterface

// ===== rtl/dfs_topo_res_if.sv =====
// Result channel interface: one vertex of the sorted order with a last flag.
interface dfs_topo_res_if;
  logic                               valid;
  logic                               ready;
  logic [dfs_topo_pkg::VERTEX_W-1:0]  vertex;
  logic                               last;

  modport source (output valid, output vertex, output last, input ready);
  modport sink (input valid, input vertex, input last, output ready);
endinterface

// ===== rtl/dfs_topo_dp.sv =====
// Datapath: adjacency RAM, visited bits, walk stack, finish list and output register.
module dfs_topo_dp #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [dfs_topo_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  logic [dfs_topo_pkg::VERTEX_W-1:0] from_vertex,
  input  logic [dfs_topo_pkg::VERTEX_W-1:0] to_vertex,
  input  dfs_topo_pkg::dp_cmd_t             ctl,
  output dfs_topo_pkg::dp_status_t          sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [dfs_topo_pkg::VERTEX_W-1:0] out_vertex,
  output logic                              out_last
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int EW = (CW > dfs_topo_pkg::COUNT_W) ? CW : dfs_topo_pkg::COUNT_W;

  logic [dfs_topo_pkg::COUNT_W-1:0] count_cfg;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] adj_row;
  logic                    adj_row_ok;
  logic [MAX_VERTICES-1:0] visited;

  logic [VW-1:0] stack_mem [MAX_VERTICES];
  logic [VW-1:0] stack_rdata;
  logic [CW-1:0] depth;
  logic [VW-1:0] top;
  logic [CW-1:0] scan_v;

  logic [VW-1:0] finish_mem [MAX_VERTICES];
  logic [VW-1:0] finish_rdata;
  logic [CW-1:0] fcount;

  logic [EW-1:0] eff_ext;
  logic [CW-1:0] eff_count;
  logic [EW-1:0] from_ext;
  logic [EW-1:0] to_ext;
  logic [VW-1:0] from_idx;
  logic          edge_ok;
  logic [MAX_VERTICES-1:0] in_range;
  logic [MAX_VERTICES-1:0] open_bits;
  logic [VW-1:0] lowest;
  logic [VW-1:0] scan_idx;
  logic [VW-1:0] push_v;
  logic          push;
  logic [CW-1:0] depth_m2;
  logic [CW-1:0] fcount_m1;
  logic [EW-1:0] vert_ext;

  // effective count = min(register, MAX_VERTICES)
  always_comb begin
    if (EW'(count_cfg) > EW'(MAX_VERTICES)) begin
      eff_ext = EW'(MAX_VERTICES);
    end else begin
      eff_ext = EW'(count_cfg);
    end
  end
  assign eff_count = eff_ext[CW-1:0];

  assign from_ext = EW'(from_vertex);
  assign to_ext   = EW'(to_vertex);
  assign from_idx = from_ext[VW-1:0];
  assign edge_ok  = (from_ext < eff_ext) && (to_ext < eff_ext);

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      in_range[i] = EW'(i) < eff_ext;
    end
  end

  assign open_bits = (adj_row_ok ? adj_row : '0) & in_range & ~visited;

  // lowest set bit of the open neighbor set
  always_comb begin
    lowest = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (open_bits[i]) begin
        lowest = VW'(i);
      end
    end
  end

  assign scan_idx  = scan_v[VW-1:0];
  assign push      = ctl.push_scan || ctl.push_open;
  assign push_v    = ctl.push_scan ? scan_idx : lowest;
  assign depth_m2  = depth - CW'(2);
  assign fcount_m1 = fcount - CW'(1);
  assign vert_ext  = EW'(finish_rdata);

  assign sts.scan_done      = scan_v >= eff_count;
  assign sts.scan_unvisited = !visited[scan_idx];
  assign sts.open_any       = |open_bits;
  assign sts.depth_one      = depth == CW'(1);
  assign sts.fcount_zero    = fcount == '0;
  assign sts.out_free       = !out_valid || out_ready;

  // adjacency RAM: masked write (whole row on first touch), registered read
  always_ff @(posedge clk) begin
    if (ctl.add_edge && edge_ok) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (!row_valid[from_idx] || to_ext == EW'(i)) begin
          adj_mem[from_idx][i] <= (to_ext == EW'(i));
        end
      end
    end
    if (ctl.row_rd) begin
      adj_row <= adj_mem[top];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[depth[VW-1:0]] <= push_v;
    end
    if (ctl.stack_rd) begin
      stack_rdata <= stack_mem[depth_m2[VW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      finish_mem[fcount[VW-1:0]] <= top;
    end
    if (ctl.emit_rd) begin
      finish_rdata <= finish_mem[fcount_m1[VW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push) begin
      top <= push_v;
    end else if (ctl.top_load) begin
      top <= stack_rdata;
    end
    if (ctl.out_load) begin
      out_vertex <= vert_ext[dfs_topo_pkg::VERTEX_W-1:0];
      out_last   <= (fcount == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_cfg  <= dfs_topo_pkg::COUNT_RESET;
      row_valid  <= '0;
      adj_row_ok <= 1'b0;
      visited    <= '0;
      depth      <= '0;
      fcount     <= '0;
      scan_v     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_cfg <= cfg_wr_data;
      end
      if (ctl.clear_graph) begin
        row_valid <= '0;
      end else if (ctl.add_edge && edge_ok) begin
        row_valid[from_idx] <= 1'b1;
      end
      if (ctl.row_rd) begin
        adj_row_ok <= row_valid[top];
      end
      if (ctl.run_start) begin
        visited <= '0;
        depth   <= '0;
        fcount  <= '0;
        scan_v  <= '0;
      end else begin
        if (ctl.scan_next) begin
          scan_v <= scan_v + CW'(1);
        end
        if (push) begin
          visited[push_v] <= 1'b1;
          depth           <= depth + CW'(1);
        end else if (ctl.pop) begin
          depth  <= depth - CW'(1);
          fcount <= fcount + CW'(1);
        end else if (ctl.emit_rd) begin
          fcount <= fcount_m1;
        end
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/dfs_topo_ctrl.sv =====
// Controller: sequences edge loads, the depth-first walk and the emit phase.
module dfs_topo_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dfs_topo_pkg::OPCODE_W-1:0] opcode,
  input  dfs_topo_pkg::dp_status_t          sts,
  output dfs_topo_pkg::dp_cmd_t             ctl
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    ROW_READ,
    EVAL,
    POP_LOAD,
    EMIT_READ,
    EMIT_LOAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      IDLE: begin
        if (accept) begin
          case (opcode)
            dfs_topo_pkg::OP_ADD_EDGE: ctl.add_edge = 1'b1;
            dfs_topo_pkg::OP_CLEAR:    ctl.clear_graph = 1'b1;
            dfs_topo_pkg::OP_RUN: begin
              ctl.run_start = 1'b1;
              state_next    = SCAN;
            end
            default: ;
          endcase
        end
      end
      SCAN: begin
        if (sts.scan_done) begin
          state_next = sts.fcount_zero ? IDLE : EMIT_READ;
        end else if (sts.scan_unvisited) begin
          ctl.push_scan = 1'b1;
          state_next    = ROW_READ;
        end else begin
          ctl.scan_next = 1'b1;
        end
      end
      ROW_READ: begin
        ctl.row_rd = 1'b1;
        state_next = EVAL;
      end
      EVAL: begin
        if (sts.open_any) begin
          ctl.push_open = 1'b1;
          state_next    = ROW_READ;
        end else begin
          ctl.pop = 1'b1;
          if (sts.depth_one) begin
            state_next = SCAN;
          end else begin
            ctl.stack_rd = 1'b1;
            state_next   = POP_LOAD;
          end
        end
      end
      POP_LOAD: begin
        ctl.top_load = 1'b1;
        state_next   = ROW_READ;
      end
      EMIT_READ: begin
        ctl.emit_rd = 1'b1;
        state_next  = EMIT_LOAD;
      end
      EMIT_LOAD: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = sts.fcount_zero ? IDLE : EMIT_READ;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/dfs_topological_sort_unit.sv =====
// DFS topological sort unit: top level joining controller, datapath and channels.
// Add-edge and clear transactions: one per cycle while the controller is idle, no result.
// Run: the walk from acceptance to the first emit read is paced by the single adjacency
// RAM read port and the stack pop read; then each result takes an emit read and an emit
// load, and waits while the result channel stalls.
// Reset (rst, synchronous): graph empty, vertex count 16, controller idle, no result pending.
module dfs_topological_sort_unit #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [dfs_topo_pkg::COUNT_W-1:0]  cfg_wr_data,
  dfs_topo_cmd_if.sink                      cmd,
  dfs_topo_res_if.source                    result
);

  // Command/status bundles between the controller and the datapath.
  dfs_topo_pkg::dp_cmd_t    ctl;
  dfs_topo_pkg::dp_status_t sts;

  // Controller: accepts a command transaction only when idle; a run then steps
  // through the scan / read / evaluate / pop loop and the emit phase.
  // No new transaction is taken until the last result is loaded.
  dfs_topo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .opcode   (cmd.opcode),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath: adjacency rows with per-row valid bits (clear resets only these bits),
  // visited vector, explicit walk stack and post-order finish list. The result
  // register decouples the output channel, so a result may wait while the
  // controller fetches the next one.
  dfs_topo_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .from_vertex (cmd.from_vertex),
    .to_vertex   (cmd.to_vertex),
    .ctl         (ctl),
    .sts         (sts),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .out_vertex  (result.vertex),
    .out_last    (result.last)
  );

endmodule
